/* rtl/svd_pkg.sv */
// svd_pkg: shared types for the singleton-values-descending block.
// Depends on nothing; used by the channel interfaces and the core.
`timescale 1ns / 1ps

package svd_pkg;

  // One 32-bit signed data word, as carried on both channels
  typedef logic signed [31:0] value_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FETCH = 6'b000010,
    ST_HOLD  = 6'b000100,
    ST_UNIQ  = 6'b001000,
    ST_SORT  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

endpackage

/* rtl/svd_in_if.sv */
// svd_in_if: valid/ready channel carrying one input value and its last flag.
// Depends on svd_pkg.
`timescale 1ns / 1ps

interface svd_in_if;
  logic            valid;
  logic            ready;
  svd_pkg::value_t value;
  logic            last_item;

  modport source (output valid, output value, output last_item, input ready);
  modport sink   (input valid, input value, input last_item, output ready);
endinterface

/* rtl/svd_out_if.sv */
// svd_out_if: valid/ready channel carrying one sorted result and its flags.
// Depends on svd_pkg.
`timescale 1ns / 1ps

interface svd_out_if;
  logic            valid;
  logic            ready;
  svd_pkg::value_t result_value;
  logic            result_last;
  logic            none_found;
  logic            overflowed;

  modport source (output valid, output result_value, output result_last,
                  output none_found, output overflowed, input ready);
  modport sink   (input valid, input result_value, input result_last,
                  input none_found, input overflowed, output ready);
endinterface

/* rtl/singleton_values_descending_core.sv */
// singleton_values_descending_core: collects a set of values, keeps those that
// occur exactly once and streams them out in descending signed order.
// Depends on svd_pkg, svd_in_if and svd_out_if.
//
// Usage:
//   in_chan takes one value per transaction; last_item closes the set. While
//   the set is loading the block is ready every cycle.
//   Up to MAX_ITEMS values are stored; later values of the same set are
//   dropped and every result of that set carries overflowed = 1.
//   After the last item the block stops accepting input. For each of the n
//   stored values it scans the whole store with an equality compare,
//   copying singletons into a second buffer. It then emits one result per
//   kept value (k in all): each result takes a scan of the kept buffer for
//   the largest value below the previous one, then waits in the output
//   register until out_chan.ready. With no singleton one result with
//   none_found = 1 and result_value = 0 is given. result_last marks the
//   final result; once it is taken the block returns to loading. A stalled
//   receiver simply holds the result. Synchronous reset empties the set and
//   drops any run in progress.
`timescale 1ns / 1ps

module singleton_values_descending_core #(
  parameter int MAX_ITEMS = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  svd_in_if.sink          in_chan,
  svd_out_if.source       out_chan
);

  localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam logic [CW-1:0] CAP = CW'(MAX_ITEMS);
  localparam logic [CW-1:0] ONE = CW'(1);

  // Storage
  svd_pkg::value_t store_mem [MAX_ITEMS];
  svd_pkg::value_t kept_mem  [MAX_ITEMS];
  svd_pkg::value_t store_rd_r;
  svd_pkg::value_t kept_rd_r;
  logic            store_we;
  logic [AW-1:0]   store_wa;
  logic [AW-1:0]   store_ra;
  logic            kept_we;
  logic [AW-1:0]   kept_ra;

  // Control state
  svd_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            ovf_r, ovf_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   j_r, j_nxt;
  logic            pend_vld_r, pend_vld_nxt;
  logic [CW-1:0]   kn_r, kn_nxt;
  logic [CW-1:0]   emit_r, emit_nxt;
  logic            has_bound_r, has_bound_nxt;
  logic            found_r, found_nxt;
  logic            dup_r, dup_nxt;
  logic            out_vld_r, out_vld_nxt;

  // Payload state
  logic [AW-1:0]   pend_idx_r, pend_idx_nxt;
  svd_pkg::value_t cur_r, cur_nxt;
  svd_pkg::value_t bound_r, bound_nxt;
  svd_pkg::value_t best_r, best_nxt;
  svd_pkg::value_t out_val_r, out_val_nxt;
  logic            out_last_r, out_last_nxt;
  logic            out_none_r, out_none_nxt;
  logic            out_ovf_r, out_ovf_nxt;

  logic            in_acc;
  logic            issue;
  logic            scan_done;
  logic            take_best;
  logic            same_val;

  assign in_chan.ready         = (state_r == svd_pkg::ST_IDLE);
  assign in_acc                = in_chan.valid && in_chan.ready;
  assign out_chan.valid        = out_vld_r;
  assign out_chan.result_value = out_val_r;
  assign out_chan.result_last  = out_last_r;
  assign out_chan.none_found   = out_none_r;
  assign out_chan.overflowed   = out_ovf_r;

  assign store_wa = cnt_r[AW-1:0];

  // Compare logic: equality for the singleton pass, signed order for
  // the selection pass
  assign same_val  = (store_rd_r == cur_r) && (pend_idx_r != i_r[AW-1:0]);
  assign take_best = (!has_bound_r || (kept_rd_r < bound_r)) &&
                     (!found_r || (kept_rd_r > best_r));

  // Store and kept buffer, one write and one registered read each
  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[store_wa] <= in_chan.value;
    end
    store_rd_r <= store_mem[store_ra];
  end

  always_ff @(posedge clk) begin
    if (kept_we) begin
      kept_mem[kn_r[AW-1:0]] <= cur_r;
    end
    kept_rd_r <= kept_mem[kept_ra];
  end

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    pend_vld_nxt  = pend_vld_r;
    pend_idx_nxt  = pend_idx_r;
    kn_nxt        = kn_r;
    emit_nxt      = emit_r;
    has_bound_nxt = has_bound_r;
    found_nxt     = found_r;
    dup_nxt       = dup_r;
    out_vld_nxt   = out_vld_r;
    cur_nxt       = cur_r;
    bound_nxt     = bound_r;
    best_nxt      = best_r;
    out_val_nxt   = out_val_r;
    out_last_nxt  = out_last_r;
    out_none_nxt  = out_none_r;
    out_ovf_nxt   = out_ovf_r;
    store_we      = 1'b0;
    kept_we       = 1'b0;
    store_ra      = i_r[AW-1:0];
    kept_ra       = j_r[AW-1:0];
    issue         = 1'b0;
    scan_done     = 1'b0;

    unique case (state_r)
      svd_pkg::ST_IDLE: begin
        // Load the set, drop what does not fit
        if (in_acc) begin
          if (cnt_r < CAP) begin
            store_we = 1'b1;
            cnt_nxt  = cnt_r + ONE;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_chan.last_item) begin
            i_nxt     = '0;
            kn_nxt    = '0;
            state_nxt = svd_pkg::ST_FETCH;
          end
        end
      end

      svd_pkg::ST_FETCH: begin
        store_ra  = i_r[AW-1:0];
        state_nxt = svd_pkg::ST_HOLD;
      end

      svd_pkg::ST_HOLD: begin
        // Hold the candidate and start a scan over the store
        cur_nxt      = store_rd_r;
        j_nxt        = '0;
        pend_vld_nxt = 1'b0;
        dup_nxt      = 1'b0;
        state_nxt    = svd_pkg::ST_UNIQ;
      end

      svd_pkg::ST_UNIQ: begin
        issue        = (j_r < cnt_r);
        store_ra     = j_r[AW-1:0];
        pend_vld_nxt = issue;
        pend_idx_nxt = j_r[AW-1:0];
        if (issue) begin
          j_nxt = j_r + ONE;
        end
        if (pend_vld_r && same_val) begin
          dup_nxt = 1'b1;
        end
        scan_done = !issue && !pend_vld_r;
        if (scan_done) begin
          // Keep the candidate if no other entry matched
          if (!dup_r) begin
            kept_we = 1'b1;
            kn_nxt  = kn_r + ONE;
          end
          i_nxt = i_r + ONE;
          if ((i_r + ONE) == cnt_r) begin
            if (dup_r && (kn_r == '0)) begin
              out_vld_nxt  = 1'b1;
              out_val_nxt  = '0;
              out_last_nxt = 1'b1;
              out_none_nxt = 1'b1;
              out_ovf_nxt  = ovf_r;
              state_nxt    = svd_pkg::ST_OUT;
            end else begin
              j_nxt         = '0;
              pend_vld_nxt  = 1'b0;
              found_nxt     = 1'b0;
              has_bound_nxt = 1'b0;
              emit_nxt      = '0;
              state_nxt     = svd_pkg::ST_SORT;
            end
          end else begin
            state_nxt = svd_pkg::ST_FETCH;
          end
        end
      end

      svd_pkg::ST_SORT: begin
        // Find the largest kept value below the previous result
        issue        = (j_r < kn_r);
        kept_ra      = j_r[AW-1:0];
        pend_vld_nxt = issue;
        if (issue) begin
          j_nxt = j_r + ONE;
        end
        if (pend_vld_r && take_best) begin
          best_nxt  = kept_rd_r;
          found_nxt = 1'b1;
        end
        scan_done = !issue && !pend_vld_r;
        if (scan_done) begin
          out_vld_nxt   = 1'b1;
          out_val_nxt   = best_r;
          out_last_nxt  = ((emit_r + ONE) == kn_r);
          out_none_nxt  = 1'b0;
          out_ovf_nxt   = ovf_r;
          emit_nxt      = emit_r + ONE;
          bound_nxt     = best_r;
          has_bound_nxt = 1'b1;
          state_nxt     = svd_pkg::ST_OUT;
        end
      end

      svd_pkg::ST_OUT: begin
        // Hold the result until the transaction completes
        if (out_chan.ready) begin
          out_vld_nxt = 1'b0;
          if (out_last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = svd_pkg::ST_IDLE;
          end else begin
            j_nxt        = '0;
            pend_vld_nxt = 1'b0;
            found_nxt    = 1'b0;
            state_nxt    = svd_pkg::ST_SORT;
          end
        end
      end

      default: begin
        state_nxt = svd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= svd_pkg::ST_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      pend_vld_r  <= 1'b0;
      kn_r        <= '0;
      emit_r      <= '0;
      has_bound_r <= 1'b0;
      found_r     <= 1'b0;
      dup_r       <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      pend_vld_r  <= pend_vld_nxt;
      kn_r        <= kn_nxt;
      emit_r      <= emit_nxt;
      has_bound_r <= has_bound_nxt;
      found_r     <= found_nxt;
      dup_r       <= dup_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pend_idx_r <= pend_idx_nxt;
    cur_r      <= cur_nxt;
    bound_r    <= bound_nxt;
    best_r     <= best_nxt;
    out_val_r  <= out_val_nxt;
    out_last_r <= out_last_nxt;
    out_none_r <= out_none_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

endmodule

/* sim/tb_top.sv */
// tb_top: self-checking bench for singleton_values_descending_core.
// Streams value sets through a bursty source and checks each sorted result
// against an in-bench ranking of singletons; needs svd_pkg, svd_in_if, svd_out_if.
`timescale 1ns / 1ps

module tb_top;

  localparam int MAX_ITEMS = 64;
  localparam int RANDOM_ITEMS = 30;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int DRAIN_CYCLES = 100;
  localparam svd_pkg::value_t VAL_MIN = 32'sh8000_0000;
  localparam svd_pkg::value_t VAL_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    svd_pkg::value_t value;
    logic            last_item;
  } in_item_t;

  typedef struct packed {
    svd_pkg::value_t result_value;
    logic            result_last;
    logic            none_found;
    logic            overflowed;
  } result_t;

  // Receiver behavior, picked at random by the sink
  typedef enum logic [1:0] {
    RX_STEADY,
    RX_RANDOM,
    RX_LONG_STALL
  } rx_mode_t;

  logic clk;
  logic rst_n;

  svd_in_if  in_chan ();
  svd_out_if out_chan ();

  singleton_values_descending_core #(
    .MAX_ITEMS (MAX_ITEMS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  in_item_t pending_items[$];
  result_t  expected_results[$];
  int       err_count = 0;

  // Ranking state: a private copy of the value store
  svd_pkg::value_t set_store[MAX_ITEMS];
  int              set_count = 0;
  logic            set_dropped = 1'b0;

  // Clock and one reset at the start
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Store one accepted value; on the closing value rank the singletons
  task automatic rank_singletons(input svd_pkg::value_t v, input logic is_last);
    svd_pkg::value_t keepers[$];
    svd_pkg::value_t hold;
    result_t         r;
    int              hits;
    int              i;
    int              j;
    if (set_count < MAX_ITEMS) begin
      set_store[set_count] = v;
      set_count++;
    end else begin
      set_dropped = 1'b1;
    end
    if (is_last) begin
      for (i = 0; i < set_count; i++) begin
        hits = 0;
        for (j = 0; j < set_count; j++) begin
          if (set_store[j] == set_store[i]) hits++;
        end
        if (hits == 1) keepers.insert(keepers.size(), set_store[i]);
      end
      // Insertion sort, largest signed value first
      for (i = 1; i < keepers.size(); i++) begin
        hold = keepers[i];
        j = i;
        while (j > 0 && keepers[j - 1] < hold) begin
          keepers[j] = keepers[j - 1];
          j--;
        end
        keepers[j] = hold;
      end
      if (keepers.size() == 0) begin
        r = '{result_value: '0, result_last: 1'b1, none_found: 1'b1,
              overflowed: set_dropped};
        expected_results.insert(expected_results.size(), r);
      end else begin
        for (i = 0; i < keepers.size(); i++) begin
          r = '{result_value: keepers[i], result_last: (i == keepers.size() - 1),
                none_found: 1'b0, overflowed: set_dropped};
          expected_results.insert(expected_results.size(), r);
        end
      end
      set_count = 0;
      set_dropped = 1'b0;
    end
  endtask

  // Source: bursts of transactions separated by random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    in_item_t nxt;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      in_chan.value <= '0;
      in_chan.last_item <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        rank_singletons(in_chan.value, in_chan.last_item);
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_chan.valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          nxt = pending_items[0];
          pending_items.delete(0);
          in_chan.valid <= 1'b1;
          in_chan.value <= nxt.value;
          in_chan.last_item <= nxt.last_item;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // Sink: check each result transaction, then pick the next ready level
  rx_mode_t rx_mode = RX_STEADY;
  int       mode_left = 0;
  int       hold_left = 0;
  logic     hold_level = 1'b1;

  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got = '{result_value: out_chan.result_value, result_last: out_chan.result_last,
                none_found: out_chan.none_found, overflowed: out_chan.overflowed};
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= SHOWN_MISMATCHES)
            $display("[%0t] unexpected result: value %0d last %b none %b ovf %b", $realtime,
                     got.result_value, got.result_last, got.none_found, got.overflowed);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got !== want) begin
            err_count++;
            if (err_count <= SHOWN_MISMATCHES)
              $display("[%0t] mismatch: value %0d/%0d last %b/%b none %b/%b ovf %b/%b",
                       $realtime, want.result_value, got.result_value, want.result_last,
                       got.result_last, want.none_found, got.none_found, want.overflowed,
                       got.overflowed);
          end
        end
      end
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 2));
        mode_left = $urandom_range(20, 300);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RX_STEADY: begin
          out_chan.ready <= 1'b1;
        end
        RX_RANDOM: begin
          out_chan.ready <= ($urandom_range(0, 9) < 7);
        end
        default: begin
          if (hold_left > 0) begin
            hold_left--;
          end else begin
            hold_level = ~hold_level;
            hold_left = hold_level ? $urandom_range(1, 4) : $urandom_range(1, 40);
          end
          out_chan.ready <= hold_level;
        end
      endcase
    end
  end

  task automatic queue_item(input svd_pkg::value_t v, input logic is_last);
    in_item_t it;
    it = '{value: v, last_item: is_last};
    pending_items.insert(pending_items.size(), it);
  endtask

  // Narrow sets draw mostly from a few small values so duplicates are common
  function automatic svd_pkg::value_t pick_value(input bit narrow);
    int k;
    k = $urandom_range(0, 5);
    if (narrow && k < 2) k = 5;
    case (k)
      0, 1: return svd_pkg::value_t'($urandom);
      2: begin
        case ($urandom_range(0, 3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return -1;
        endcase
      end
      default: return svd_pkg::value_t'(int'($urandom_range(0, 6)) - 3);
    endcase
  endfunction

  initial begin : stimulus
    int   n_random;
    int   set_len;
    int   i;
    bit   narrow;
    // Single-value set
    queue_item(0, 1'b1);
    // Extremes and signs, all unique
    queue_item(VAL_MAX, 1'b0);
    queue_item(VAL_MIN, 1'b0);
    queue_item(-1, 1'b0);
    queue_item(1, 1'b0);
    queue_item(0, 1'b0);
    queue_item(32'sh5555_5555, 1'b1);
    // Pair only: nothing unique
    queue_item(5, 1'b0);
    queue_item(5, 1'b1);
    // Repeated values drop out entirely
    queue_item(7, 1'b0);
    queue_item(-7, 1'b0);
    queue_item(7, 1'b0);
    queue_item(7, 1'b0);
    queue_item(-8, 1'b1);
    // Duplicate at the low extreme
    queue_item(VAL_MIN, 1'b0);
    queue_item(VAL_MIN, 1'b0);
    queue_item(VAL_MAX, 1'b1);
    // Two pairs
    queue_item(3, 1'b0);
    queue_item(3, 1'b0);
    queue_item(9, 1'b0);
    queue_item(9, 1'b1);
    // Alternating bit patterns
    queue_item(32'shAAAA_AAAA, 1'b0);
    queue_item(32'sh5555_5554, 1'b1);

    // Store filled, then overrun with the closing value dropped
    for (i = 0; i < MAX_ITEMS + 2; i++) queue_item(pick_value(1'b0), i == MAX_ITEMS + 1);

    // Random sets of small size
    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      set_len = $urandom_range(1, 12);
      narrow = $urandom_range(0, 1);
      for (i = 0; i < set_len; i++) queue_item(pick_value(narrow), i == set_len - 1);
      n_random += set_len;
    end

    // Drain: all items sent and every expected result taken
    @(negedge clk);
    while (!(rst_n && pending_items.size() == 0 && !in_chan.valid &&
             expected_results.size() == 0))
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Hard stop for a hung run
  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
